@@ rtl/core/brf_pkg.sv @@
package brf_pkg;

  // Storage depth and derived widths
  localparam int DEPTH  = 1024;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int AMT_W  = 11;
  localparam int FILL_W = 11;
  localparam int BYTE_W = 8;
  localparam int CMP_W  = (AMT_W > CNT_W) ? AMT_W : CNT_W;

  // Stream payload widths (whole bytes)
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OP_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_SKIP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } brf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } brf_sts_t;

  // Pointer advance with wrap; ptr < DEPTH and n <= DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(ptr) + SUM_W'(n);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ rtl/core/brf_ctrl.sv @@
module brf_ctrl
  import brf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  brf_sts_t sts,
  output brf_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_EMIT: cmd.emit = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/brf_datapath.sv @@
module brf_datapath
  import brf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  brf_cmd_t              cmd,
  output brf_sts_t              sts,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  // Byte store, contents undefined until written
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] mem_q_r;

  // Item held for execution
  op_t               op_r;
  logic [BYTE_W-1:0] din_r;
  logic [AMT_W-1:0]  amt_r;

  // FIFO control state
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Result held while the store is read
  logic             res_ok_r, res_ok_nxt;
  logic             res_rd_r, res_rd_nxt;
  logic [CNT_W-1:0] res_cnt_r;

  // Output register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  logic             mem_we;
  logic [PTR_W-1:0] rd_addr;
  logic             amt_lt;
  logic [CNT_W-1:0] skip_n;

  assign amt_lt = CMP_W'(amt_r) < CMP_W'(cnt_r);
  assign skip_n = amt_lt ? CNT_W'(amt_r) : cnt_r;

  // Operation decode and pointer update
  always_comb begin
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    res_ok_nxt = 1'b0;
    res_rd_nxt = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = rp_r;
    unique case (op_r)
      OP_WRITE: begin
        if (cnt_r < CNT_W'(DEPTH)) begin
          mem_we     = 1'b1;
          wp_nxt     = wrap_add(wp_r, CNT_W'(1));
          cnt_nxt    = cnt_r + CNT_W'(1);
          res_ok_nxt = 1'b1;
        end
      end
      OP_READ: begin
        if (cnt_r != '0) begin
          rp_nxt     = wrap_add(rp_r, CNT_W'(1));
          cnt_nxt    = cnt_r - CNT_W'(1);
          res_ok_nxt = 1'b1;
          res_rd_nxt = 1'b1;
        end
      end
      OP_PEEK: begin
        rd_addr = wrap_add(rp_r, CNT_W'(amt_r));
        if (amt_lt) begin
          res_ok_nxt = 1'b1;
          res_rd_nxt = 1'b1;
        end
      end
      OP_SKIP: begin
        rp_nxt     = wrap_add(rp_r, skip_n);
        cnt_nxt    = cnt_r - skip_n;
        res_ok_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[wp_r] <= din_r;
    end
    if (cmd.exec) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Item capture and result hold
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_tuser);
      din_r <= in_tdata[BYTE_W-1:0];
      amt_r <= in_tdata[BYTE_W +: AMT_W];
    end
    if (cmd.exec) begin
      res_ok_r  <= res_ok_nxt;
      res_rd_r  <= res_rd_nxt;
      res_cnt_r <= cnt_nxt;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.exec) begin
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Output register: data_out then fill_count, zero padded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {(OUT_DATA_W - BYTE_W - FILL_W)'(0), FILL_W'(res_cnt_r),
                      res_rd_r ? mem_q_r : BYTE_W'(0)};
      out_tuser_r <= res_ok_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser    = out_tuser_r;
  assign sts.out_free = !out_tvalid_r || out_tready;

  // Write pointer leads read pointer by the fill count
  logic [SUM_W-1:0] lead_sum;
  logic             ptr_consistent;
  assign lead_sum       = SUM_W'(rp_r) + SUM_W'(cnt_r);
  assign ptr_consistent = (SUM_W'(wp_r) == lead_sum) ||
                          (SUM_W'(wp_r) == lead_sum - SUM_W'(DEPTH));

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_consistent)
    else $error("pointers disagree with fill count");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tuser_r) |-> (out_tdata_r[BYTE_W-1:0] == '0))
    else $error("failed transaction carries data");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.exec) |-> $stable(cnt_r))
    else $error("fill count moved outside execute");

endmodule

@@ rtl/core/byte_ring_fifo.sv @@
// Steps: a transaction is accepted in the idle state, then executed (store access with
// registered read), then emitted into the output register once out_* is free, so it
// can stall there. The steps run in sequence: a new transaction is accepted only after
// the last one has been emitted.
// Reset: rst_n low at a clock edge clears the pointers, fill count and output valid.
// The byte store is not cleared: only data from written entries ever reaches data_out.
module byte_ring_fifo
  import brf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_in, [18:8] amount, [23:19] zero
  input  logic [OP_W-1:0]       in_tuser,   // [1:0] op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] data_out, [18:8] fill_count, [23:19] zero
  output logic                  out_tuser   // [0] ok
);

  brf_cmd_t cmd;
  brf_sts_t sts;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ sim/byte_ring_fifo_test.sv @@
module byte_ring_fifo_test;
  import brf_pkg::*;

  localparam int N_DIR        = 25;
  localparam int N_RAND_PHASE = 110;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG_MAX = 4000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              ok;
    logic [FILL_W-1:0] fill;
  } fifo_res_t;

  typedef struct {
    op_t              op;
    logic [BYTE_W-1:0] din;
    logic [AMT_W-1:0]  amt;
    bit                typed;
    fifo_res_t         res;
  } dir_row_t;

  typedef struct {
    bit        typed;
    fifo_res_t res;
  } typed_tag_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Traffic shaping, set per phase
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req     = 1'b0;

  // Mirror of the FIFO contents and pointers
  logic [BYTE_W-1:0] mirror_store [DEPTH];
  int                mirror_rd   = 0;
  int                mirror_wr   = 0;
  int                mirror_held = 0;

  fifo_res_t  pending_q [$];
  typed_tag_t typed_q   [$];

  int fail_count  = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int n_full_drop = 0;
  int n_refused   = 0;
  int n_clamped   = 0;
  int n_wrapped   = 0;
  int idle_cycles = 0;

  // Directed rows: typed results where they are obvious, the rest from the mirror
  dir_row_t dir_rows [N_DIR] = '{
    '{OP_READ,  8'h00, 11'd0,    1'b1, '{8'h00, 1'b0, 11'd0}},
    '{OP_PEEK,  8'h00, 11'd0,    1'b1, '{8'h00, 1'b0, 11'd0}},
    '{OP_SKIP,  8'h00, 11'd5,    1'b1, '{8'h00, 1'b1, 11'd0}},
    '{OP_SKIP,  8'h00, 11'd0,    1'b1, '{8'h00, 1'b1, 11'd0}},
    '{OP_WRITE, 8'h00, 11'd0,    1'b1, '{8'h00, 1'b1, 11'd1}},
    '{OP_WRITE, 8'hFF, 11'd1024, 1'b1, '{8'h00, 1'b1, 11'd2}},
    '{OP_WRITE, 8'hA5, 11'd1023, 1'b1, '{8'h00, 1'b1, 11'd3}},
    '{OP_WRITE, 8'h5A, 11'd0,    1'b1, '{8'h00, 1'b1, 11'd4}},
    '{OP_PEEK,  8'h00, 11'd0,    1'b1, '{8'h00, 1'b1, 11'd4}},
    '{OP_PEEK,  8'h00, 11'd3,    1'b0, '{8'h00, 1'b0, 11'd0}},
    '{OP_PEEK,  8'h00, 11'd4,    1'b1, '{8'h00, 1'b0, 11'd4}},
    '{OP_PEEK,  8'h00, 11'd1023, 1'b1, '{8'h00, 1'b0, 11'd4}},
    '{OP_PEEK,  8'hFF, 11'd1024, 1'b1, '{8'h00, 1'b0, 11'd4}},
    '{OP_READ,  8'h00, 11'd0,    1'b1, '{8'h00, 1'b1, 11'd3}},
    '{OP_READ,  8'h00, 11'd0,    1'b1, '{8'hFF, 1'b1, 11'd2}},
    '{OP_SKIP,  8'h00, 11'd0,    1'b1, '{8'h00, 1'b1, 11'd2}},
    '{OP_SKIP,  8'h00, 11'd1,    1'b1, '{8'h00, 1'b1, 11'd1}},
    '{OP_PEEK,  8'h00, 11'd0,    1'b0, '{8'h00, 1'b0, 11'd0}},
    '{OP_SKIP,  8'h00, 11'd1024, 1'b1, '{8'h00, 1'b1, 11'd0}},
    '{OP_READ,  8'h00, 11'd0,    1'b1, '{8'h00, 1'b0, 11'd0}},
    '{OP_WRITE, 8'h3C, 11'd0,    1'b0, '{8'h00, 1'b0, 11'd0}},
    '{OP_WRITE, 8'h81, 11'd0,    1'b0, '{8'h00, 1'b0, 11'd0}},
    '{OP_PEEK,  8'h00, 11'd1,    1'b0, '{8'h00, 1'b0, 11'd0}},
    '{OP_SKIP,  8'h00, 11'd3,    1'b1, '{8'h00, 1'b1, 11'd0}},
    '{OP_WRITE, 8'hC3, 11'd0,    1'b0, '{8'h00, 1'b0, 11'd0}}
  };

  byte_ring_fifo u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one operation to the mirror and return the result it should give
  function automatic fifo_res_t apply_fifo_op(op_t op, logic [BYTE_W-1:0] din,
                                              logic [AMT_W-1:0] amt);
    fifo_res_t r;
    int        n;
    r = '{data: '0, ok: 1'b0, fill: '0};
    case (op)
      OP_WRITE: begin
        if (mirror_held < DEPTH) begin
          mirror_store[mirror_wr] = din;
          if (mirror_wr == DEPTH - 1) n_wrapped++;
          mirror_wr = (mirror_wr + 1) % DEPTH;
          mirror_held++;
          r.ok = 1'b1;
        end else begin
          n_full_drop++;
        end
      end
      OP_READ: begin
        if (mirror_held != 0) begin
          r.data = mirror_store[mirror_rd];
          mirror_rd = (mirror_rd + 1) % DEPTH;
          mirror_held--;
          r.ok = 1'b1;
        end else begin
          n_refused++;
        end
      end
      OP_PEEK: begin
        if (int'(amt) < mirror_held) begin
          r.data = mirror_store[(mirror_rd + int'(amt)) % DEPTH];
          r.ok = 1'b1;
        end else begin
          n_refused++;
        end
      end
      default: begin
        n = (int'(amt) < mirror_held) ? int'(amt) : mirror_held;
        if (int'(amt) > mirror_held) n_clamped++;
        mirror_rd = (mirror_rd + n) % DEPTH;
        mirror_held -= n;
        r.ok = 1'b1;
      end
    endcase
    r.fill = FILL_W'(mirror_held);
    return r;
  endfunction

  // Offer one transaction, with a random gap first, and wait for it to be taken
  task automatic send_op(op_t op, logic [BYTE_W-1:0] din, logic [AMT_W-1:0] amt,
                         bit typed, fifo_res_t res);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b00000, amt, din};
    in_tuser  <= op;
    typed_q.push_back('{typed, res});
    do @(posedge clk); while (!in_tready);
  endtask

  // Random operation, shaped by the current fill so that peeks and skips mostly land
  task automatic send_random_op();
    int unsigned      pick;
    op_t              op;
    logic [AMT_W-1:0] amt;
    int               held;
    held = mirror_held;
    pick = $urandom_range(99);
    if (pick < 45)      op = OP_WRITE;
    else if (pick < 70) op = OP_READ;
    else if (pick < 88) op = OP_PEEK;
    else                op = OP_SKIP;
    amt = AMT_W'($urandom_range(1024));
    if (op == OP_PEEK && held > 0 && $urandom_range(99) < 80) begin
      amt = AMT_W'($urandom_range(held - 1));
    end else if (op == OP_SKIP) begin
      pick = $urandom_range(99);
      if (pick < 60)      amt = AMT_W'($urandom_range(3));
      else if (pick < 85) amt = AMT_W'($urandom_range((held + 2 > 1024) ? 1024 : held + 2));
    end
    send_op(op, 8'($urandom_range(255)), amt, 1'b0, '0);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : rx_ctrl
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Check results against the oldest expectation, then record new transactions
  always @(posedge clk) begin : monitor
    fifo_res_t  got;
    fifo_res_t  want;
    fifo_res_t  pred;
    typed_tag_t tag;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{data: out_tdata[7:0], ok: out_tuser, fill: out_tdata[18:8]};
        n_results++;
        if (pending_q.size() == 0) begin
          $error("unexpected result transaction: data_out %0h ok %0b fill_count %0d",
                 got.data, got.ok, got.fill);
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          if (got.data !== want.data) begin
            $error("data_out: expected %0h, actual %0h", want.data, got.data);
            fail_count++;
          end
          if (got.ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, got.ok);
            fail_count++;
          end
          if (got.fill !== want.fill) begin
            $error("fill_count: expected %0d, actual %0d", want.fill, got.fill);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        n_accepted++;
        pred = apply_fifo_op(op_t'(in_tuser), in_tdata[7:0], in_tdata[18:8]);
        tag = typed_q.pop_front();
        pending_q.push_back(tag.typed ? tag.res : pred);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned tx_pct [4];
    int unsigned rx_pct [4];
    tx_pct = '{0, 65, 0, 38};
    rx_pct = '{0, 0, 65, 38};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, no idling
    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].op, dir_rows[i].din, dir_rows[i].amt, dir_rows[i].typed,
              dir_rows[i].res);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      for (int k = 0; k < N_RAND_PHASE; k++) begin
        // long receiver hold-off while transactions keep coming
        if (ph == 1 && k == 40) hold_req = 1'b1;
        send_random_op();
      end
      if (ph == 0) begin
        // Fill to the brim across the pointer wrap, push against full, then empty
        while (mirror_held < DEPTH) begin
          send_op(OP_WRITE, 8'($urandom_range(255)), AMT_W'($urandom_range(1024)), 1'b0, '0);
        end
        repeat (4) send_op(OP_WRITE, 8'($urandom_range(255)), 11'd0, 1'b0, '0);
        send_op(OP_PEEK, 8'h00, AMT_W'(DEPTH - 1), 1'b0, '0);
        send_op(OP_PEEK, 8'h00, 11'd1024, 1'b0, '0);
        repeat (6) send_op(OP_PEEK, 8'h00, AMT_W'($urandom_range(DEPTH - 1)), 1'b0, '0);
        send_op(OP_READ, 8'h00, 11'd0, 1'b0, '0);
        send_op(OP_WRITE, 8'($urandom_range(255)), 11'd0, 1'b0, '0);
        send_op(OP_SKIP, 8'h00, 11'd1024, 1'b0, '0);
        send_op(OP_READ, 8'h00, 11'd0, 1'b0, '0);
      end
      // sender waits for every outstanding result before the next phase
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d transactions in and %0d results out over four traffic phases.",
             n_accepted, n_results);
    $display("Writes refused at full: %0d, reads/peeks refused: %0d, clamped skips: %0d, wraps: %0d.",
             n_full_drop, n_refused, n_clamped, n_wrapped);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_q.size() != 0) $error("%0d expected results never arrived", pending_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
